// ----- hw/rtl/cpu6502_pkg.sv -----
// ----------------------------------------------------------------------------
// 6502 subset executor package
// Shared commands, instruction classes and the opcode decode function.
// ----------------------------------------------------------------------------
package cpu6502_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_EXEC  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    MODE_IMM, MODE_ABS, MODE_ABX, MODE_ABY, MODE_ZP,
    MODE_ZPX, MODE_ZPY, MODE_IZX, MODE_IZY
  } mode_t;

  typedef enum logic [3:0] {
    KIND_LOAD, KIND_STORE, KIND_ADC, KIND_TAX, KIND_TAY, KIND_TXA, KIND_TYA,
    KIND_TSX, KIND_TXS, KIND_JMP, KIND_JSR, KIND_RTS, KIND_SEC, KIND_CLC,
    KIND_NOP, KIND_BAD
  } kind_t;

  typedef enum logic [1:0] {
    REG_A = 2'd0,
    REG_X = 2'd1,
    REG_Y = 2'd2
  } reg_sel_t;

  typedef struct packed {
    kind_t    kind;
    mode_t    mode;
    reg_sel_t sel;
  } decode_t;

  localparam logic [15:0] STACK_PAGE = 16'h0100;

  function automatic decode_t decode_op(input logic [7:0] op);
    decode_t d;
    d = '{kind: KIND_BAD, mode: MODE_IMM, sel: REG_A};
    case (op)
      8'hA9: d = '{KIND_LOAD, MODE_IMM, REG_A};
      8'hA2: d = '{KIND_LOAD, MODE_IMM, REG_X};
      8'hA0: d = '{KIND_LOAD, MODE_IMM, REG_Y};
      8'hAD: d = '{KIND_LOAD, MODE_ABS, REG_A};
      8'hAE: d = '{KIND_LOAD, MODE_ABS, REG_X};
      8'hAC: d = '{KIND_LOAD, MODE_ABS, REG_Y};
      8'hBD: d = '{KIND_LOAD, MODE_ABX, REG_A};
      8'hBC: d = '{KIND_LOAD, MODE_ABX, REG_Y};
      8'hB9: d = '{KIND_LOAD, MODE_ABY, REG_A};
      8'hBE: d = '{KIND_LOAD, MODE_ABY, REG_X};
      8'hA5: d = '{KIND_LOAD, MODE_ZP, REG_A};
      8'hA6: d = '{KIND_LOAD, MODE_ZP, REG_X};
      8'hA4: d = '{KIND_LOAD, MODE_ZP, REG_Y};
      8'hB5: d = '{KIND_LOAD, MODE_ZPX, REG_A};
      8'hB4: d = '{KIND_LOAD, MODE_ZPX, REG_Y};
      8'hB6: d = '{KIND_LOAD, MODE_ZPY, REG_X};
      8'hA1: d = '{KIND_LOAD, MODE_IZX, REG_A};
      8'hB1: d = '{KIND_LOAD, MODE_IZY, REG_A};
      8'h8D: d = '{KIND_STORE, MODE_ABS, REG_A};
      8'h8E: d = '{KIND_STORE, MODE_ABS, REG_X};
      8'h8C: d = '{KIND_STORE, MODE_ABS, REG_Y};
      8'h9D: d = '{KIND_STORE, MODE_ABX, REG_A};
      8'h99: d = '{KIND_STORE, MODE_ABY, REG_A};
      8'h85: d = '{KIND_STORE, MODE_ZP, REG_A};
      8'h86: d = '{KIND_STORE, MODE_ZP, REG_X};
      8'h84: d = '{KIND_STORE, MODE_ZP, REG_Y};
      8'h95: d = '{KIND_STORE, MODE_ZPX, REG_A};
      8'h94: d = '{KIND_STORE, MODE_ZPX, REG_Y};
      8'h96: d = '{KIND_STORE, MODE_ZPY, REG_X};
      8'h81: d = '{KIND_STORE, MODE_IZX, REG_A};
      8'h91: d = '{KIND_STORE, MODE_IZY, REG_A};
      8'h69: d = '{KIND_ADC, MODE_IMM, REG_A};
      8'h6D: d = '{KIND_ADC, MODE_ABS, REG_A};
      8'h7D: d = '{KIND_ADC, MODE_ABX, REG_A};
      8'h79: d = '{KIND_ADC, MODE_ABY, REG_A};
      8'h65: d = '{KIND_ADC, MODE_ZP, REG_A};
      8'h75: d = '{KIND_ADC, MODE_ZPX, REG_A};
      8'h61: d = '{KIND_ADC, MODE_IZX, REG_A};
      8'h71: d = '{KIND_ADC, MODE_IZY, REG_A};
      8'h8A: d.kind = KIND_TXA;
      8'h98: d.kind = KIND_TYA;
      8'hA8: d.kind = KIND_TAY;
      8'hAA: d.kind = KIND_TAX;
      8'hBA: d.kind = KIND_TSX;
      8'h9A: d.kind = KIND_TXS;
      8'h4C: d.kind = KIND_JMP;
      8'h20: d.kind = KIND_JSR;
      8'h60: d.kind = KIND_RTS;
      8'h38: d.kind = KIND_SEC;
      8'h18: d.kind = KIND_CLC;
      8'hEA: d.kind = KIND_NOP;
      default: d.kind = KIND_BAD;
    endcase
    return d;
  endfunction

endpackage

// ----- hw/rtl/cpu6502_mem.sv -----
// ----------------------------------------------------------------------------
// 6502 subset executor byte memory
// Single-port synchronous RAM, one access a cycle, registered read data.
// ----------------------------------------------------------------------------
module cpu6502_mem #(
  parameter int MEMORY_WORDS = 65536
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(MEMORY_WORDS)-1:0] addr,
  input  logic [7:0]                      wdata,
  output logic [7:0]                      rdata
);

  logic [7:0] mem [MEMORY_WORDS];

  // write or read one byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hw/rtl/cpu6502_subset_executor.sv -----
// ----------------------------------------------------------------------------
// 6502 subset executor
// Runs memory commands and single 6502 subset instructions on a byte RAM.
// ----------------------------------------------------------------------------
// One item at a time. The single-port RAM gives one access a cycle with
// registered read data, so each memory access of an item takes its own
// state. A memory write, a memory read or an idle command passes through
// S_WAIT to S_OUT. An instruction fetches its opcode and operand bytes,
// then any pointer or stack bytes, then its data, and presents its result
// in S_OUT. No clearing pass after reset.
module cpu6502_subset_executor #(
  parameter int MEMORY_WORDS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [15:0] address,
  input  logic [7:0]  write_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_value,
  output logic [7:0]  accumulator,
  output logic [7:0]  index_x,
  output logic [7:0]  index_y,
  output logic [7:0]  stack_pointer,
  output logic [15:0] program_counter,
  output logic        carry_flag,
  output logic        zero_flag,
  output logic        negative_flag,
  output logic        status
);

  localparam int AW = $clog2(MEMORY_WORDS);

  typedef enum logic [3:0] {
    S_IDLE, S_WAIT, S_OPC, S_OP1, S_OP2, S_PTR1, S_PTR2, S_DATA, S_PUSH2,
    S_PULL2, S_DONE, S_OUT
  } state_t;

  state_t state;
  logic [7:0] acc, xr, yr, sp;
  logic [15:0] pc;
  logic [8:0] last;
  logic has_run;
  logic [1:0] cmd;
  cpu6502_pkg::decode_t dec;
  cpu6502_pkg::decode_t op_dec;
  logic [15:0] ea;
  logic [7:0] lo;
  logic mem_we;
  logic [15:0] mem_a;
  logic [7:0] mem_wd, mem_rd;
  logic [8:0] sum;
  logic [7:0] st_val;

  cpu6502_mem #(.MEMORY_WORDS(MEMORY_WORDS)) u_mem (
    .clk(clk), .we(mem_we), .addr(mem_a[AW-1:0]), .wdata(mem_wd), .rdata(mem_rd)
  );

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign accumulator = acc;
  assign index_x = xr;
  assign index_y = yr;
  assign stack_pointer = sp;
  assign program_counter = pc;
  assign carry_flag = last[8];
  assign zero_flag = (last[7:0] == 8'd0);
  assign negative_flag = last[7];
  assign sum = {1'b0, acc} + {8'd0, last[8]} + {1'b0, mem_rd};
  assign op_dec = cpu6502_pkg::decode_op(mem_rd);

  always_comb begin
    case (dec.sel)
      cpu6502_pkg::REG_X: st_val = xr;
      cpu6502_pkg::REG_Y: st_val = yr;
      default: st_val = acc;
    endcase
  end

  // drive the RAM port from the state and held addresses
  always_comb begin
    mem_we = 1'b0;
    mem_a = pc;
    mem_wd = write_value;
    case (state)
      S_IDLE: begin
        mem_a = address;
        mem_we = in_valid && (cpu6502_pkg::cmd_t'(command) == cpu6502_pkg::CMD_WRITE);
      end
      S_PTR1: mem_a = ea;
      S_PTR2: mem_a = {ea[15:8], ea[7:0] + 8'd1};
      S_DATA: begin
        mem_a = ea;
        mem_we = (dec.kind == cpu6502_pkg::KIND_STORE);
        mem_wd = st_val;
      end
      S_PUSH2: begin
        mem_a = cpu6502_pkg::STACK_PAGE | {8'd0, sp};
        mem_we = 1'b1;
        mem_wd = ea[15:8];
      end
      S_DONE: begin
        mem_a = cpu6502_pkg::STACK_PAGE | {8'd0, sp - 8'd1};
        mem_we = (dec.kind == cpu6502_pkg::KIND_JSR);
        mem_wd = ea[7:0];
      end
      default: mem_a = pc;
    endcase
  end

  // sequence the accesses of one item
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      acc <= '0; xr <= '0; yr <= '0; sp <= '0;
      pc <= '0; last <= 9'd1; has_run <= 1'b0; status <= 1'b0;
    end else begin
      if (cfg_we && !has_run) pc <= cfg_wdata;
      case (state)
        S_IDLE: if (in_valid) begin
          cmd <= command;
          read_value <= '0;
          status <= 1'b0;
          if (cpu6502_pkg::cmd_t'(command) == cpu6502_pkg::CMD_EXEC) begin
            has_run <= 1'b1;
            state <= S_OPC;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (cpu6502_pkg::cmd_t'(cmd) == cpu6502_pkg::CMD_READ) read_value <= mem_rd;
          state <= S_OUT;
        end
        S_OPC: begin
          // opcode address is on the port in this state; the byte arrives in S_OP1
          pc <= pc + 16'd1;
          state <= S_OP1;
        end
        S_OP1: begin
          dec <= op_dec;
          case (op_dec.kind)
            cpu6502_pkg::KIND_LOAD, cpu6502_pkg::KIND_STORE, cpu6502_pkg::KIND_ADC: begin
              if (op_dec.mode == cpu6502_pkg::MODE_IMM) begin
                // the operand byte itself is the data
                ea <= pc;
                pc <= pc + 16'd1;
                state <= S_DATA;
              end else begin
                // first operand byte is being read at pc
                pc <= pc + 16'd1;
                state <= S_OP2;
              end
            end
            cpu6502_pkg::KIND_JMP, cpu6502_pkg::KIND_JSR: begin
              pc <= pc + 16'd1;
              state <= S_OP2;
            end
            cpu6502_pkg::KIND_RTS: begin
              // pull the return address through the pointer states
              ea <= cpu6502_pkg::STACK_PAGE | {8'd0, sp + 8'd1};
              state <= S_PTR1;
            end
            default: begin
              state <= S_DONE;
              case (op_dec.kind)
                cpu6502_pkg::KIND_TXA: begin acc <= xr; last[7:0] <= xr; end
                cpu6502_pkg::KIND_TYA: begin acc <= yr; last[7:0] <= yr; end
                cpu6502_pkg::KIND_TAY: begin yr <= acc; last[7:0] <= acc; end
                cpu6502_pkg::KIND_TAX: begin xr <= acc; last[7:0] <= acc; end
                cpu6502_pkg::KIND_TSX: begin xr <= sp; last[7:0] <= sp; end
                cpu6502_pkg::KIND_TXS: sp <= xr;
                cpu6502_pkg::KIND_SEC: last[8] <= 1'b1;
                cpu6502_pkg::KIND_CLC: last[8] <= 1'b0;
                cpu6502_pkg::KIND_BAD: status <= 1'b1;
                default: ;
              endcase
            end
          endcase
        end
        S_OP2: begin
          // mem_rd is byte at pc-1 (low operand); pc addresses high byte
          lo <= mem_rd;
          case (dec.mode)
            cpu6502_pkg::MODE_ZP: begin ea <= {8'd0, mem_rd}; state <= S_DATA; end
            cpu6502_pkg::MODE_ZPX: begin ea <= {8'd0, mem_rd + xr}; state <= S_DATA; end
            cpu6502_pkg::MODE_ZPY: begin ea <= {8'd0, mem_rd + yr}; state <= S_DATA; end
            cpu6502_pkg::MODE_IZX: begin ea <= {8'd0, mem_rd + xr}; state <= S_PTR1; end
            cpu6502_pkg::MODE_IZY: begin ea <= {8'd0, mem_rd}; state <= S_PTR1; end
            default: begin pc <= pc + 16'd1; state <= S_PTR1; end
          endcase
        end
        S_PTR1: begin
          // absolute forms: mem_rd is the high operand byte
          // indirect and RTS: low pointer byte address is on the port now
          case (dec.kind)
            cpu6502_pkg::KIND_JMP: begin pc <= {mem_rd, lo}; state <= S_OUT; end
            cpu6502_pkg::KIND_JSR: begin
              ea <= pc - 16'd1;
              pc <= {mem_rd, lo};
              state <= S_PUSH2;
            end
            default: begin
              case (dec.mode)
                cpu6502_pkg::MODE_ABS: begin ea <= {mem_rd, lo}; state <= S_DATA; end
                cpu6502_pkg::MODE_ABX: begin
                  ea <= {mem_rd, lo} + {8'd0, xr}; state <= S_DATA;
                end
                cpu6502_pkg::MODE_ABY: begin
                  ea <= {mem_rd, lo} + {8'd0, yr}; state <= S_DATA;
                end
                default: state <= S_PTR2;
              endcase
            end
          endcase
        end
        S_PTR2: begin
          // high pointer byte address on the port; low byte arrives now
          lo <= mem_rd;
          state <= S_PULL2;
        end
        S_PULL2: begin
          // high byte arrives now
          if (dec.kind == cpu6502_pkg::KIND_RTS) begin
            pc <= {mem_rd, lo} + 16'd1;
            sp <= sp + 8'd2;
            state <= S_OUT;
          end else begin
            if (dec.mode == cpu6502_pkg::MODE_IZY) ea <= {mem_rd, lo} + {8'd0, yr};
            else ea <= {mem_rd, lo};
            state <= S_DATA;
          end
        end
        S_DATA: begin
          state <= (dec.kind == cpu6502_pkg::KIND_STORE) ? S_OUT : S_DONE;
        end
        S_PUSH2: state <= S_DONE;
        S_DONE: begin
          case (dec.kind)
            cpu6502_pkg::KIND_LOAD: begin
              last[7:0] <= mem_rd;
              case (dec.sel)
                cpu6502_pkg::REG_X: xr <= mem_rd;
                cpu6502_pkg::REG_Y: yr <= mem_rd;
                default: acc <= mem_rd;
              endcase
            end
            cpu6502_pkg::KIND_ADC: begin last <= sum; acc <= sum[7:0]; end
            cpu6502_pkg::KIND_JSR: sp <= sp - 8'd2;
            default: ;
          endcase
          state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst) in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output both open");

endmodule

// ----- verif/cpu6502_subset_checker.sv -----
// ----------------------------------------------------------------------------
// 6502 subset executor result checker
// Watches the configuration port and both item channels, keeps its own copy
// of the register file and byte memory, predicts one result per accepted
// item and compares every delivered result field by field in order.
// ----------------------------------------------------------------------------
module cpu6502_subset_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  command,
  input  logic [15:0] address,
  input  logic [7:0]  write_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  read_value,
  input  logic [7:0]  accumulator,
  input  logic [7:0]  index_x,
  input  logic [7:0]  index_y,
  input  logic [7:0]  stack_pointer,
  input  logic [15:0] program_counter,
  input  logic        carry_flag,
  input  logic        zero_flag,
  input  logic        negative_flag,
  input  logic        status,
  output int          fail_count
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  rdata;
    logic [7:0]  acc;
    logic [7:0]  xr;
    logic [7:0]  yr;
    logic [7:0]  sp;
    logic [15:0] pc;
    logic        c;
    logic        z;
    logic        n;
    logic        bad_op;
  } cpu_result_t;

  // Predicted machine state
  logic [7:0]  mem_q [65536];
  bit          written_q [65536];
  logic [7:0]  acc_q, x_q, y_q, sp_q;
  logic [15:0] pc_q, start_q;
  logic [8:0]  flags_q;
  bit          ran_q;

  cpu_result_t results_due [$];
  int          mismatches;

  assign fail_count = mismatches + results_due.size();

  // Instruction class, addressing mode and register for one opcode
  function automatic cpu6502_pkg::decode_t classify(input logic [7:0] op);
    cpu6502_pkg::decode_t d;
    d.mode = cpu6502_pkg::MODE_IMM;
    d.sel  = cpu6502_pkg::REG_A;
    case (op)
      8'hA9, 8'hA2, 8'hA0, 8'hAD, 8'hAE, 8'hAC, 8'hBD, 8'hBC, 8'hB9, 8'hBE,
      8'hA5, 8'hA6, 8'hA4, 8'hB5, 8'hB4, 8'hB6, 8'hA1, 8'hB1:
        d.kind = cpu6502_pkg::KIND_LOAD;
      8'h8D, 8'h8E, 8'h8C, 8'h9D, 8'h99, 8'h85, 8'h86, 8'h84, 8'h95, 8'h94,
      8'h96, 8'h81, 8'h91: d.kind = cpu6502_pkg::KIND_STORE;
      8'h69, 8'h6D, 8'h7D, 8'h79, 8'h65, 8'h75, 8'h61, 8'h71:
        d.kind = cpu6502_pkg::KIND_ADC;
      8'h8A: d.kind = cpu6502_pkg::KIND_TXA;
      8'h98: d.kind = cpu6502_pkg::KIND_TYA;
      8'hA8: d.kind = cpu6502_pkg::KIND_TAY;
      8'hAA: d.kind = cpu6502_pkg::KIND_TAX;
      8'hBA: d.kind = cpu6502_pkg::KIND_TSX;
      8'h9A: d.kind = cpu6502_pkg::KIND_TXS;
      8'h4C: d.kind = cpu6502_pkg::KIND_JMP;
      8'h20: d.kind = cpu6502_pkg::KIND_JSR;
      8'h60: d.kind = cpu6502_pkg::KIND_RTS;
      8'h38: d.kind = cpu6502_pkg::KIND_SEC;
      8'h18: d.kind = cpu6502_pkg::KIND_CLC;
      8'hEA: d.kind = cpu6502_pkg::KIND_NOP;
      default: d.kind = cpu6502_pkg::KIND_BAD;
    endcase
    case (op)
      8'hAD, 8'hAE, 8'hAC, 8'h8D, 8'h8E, 8'h8C, 8'h6D: d.mode = cpu6502_pkg::MODE_ABS;
      8'hBD, 8'hBC, 8'h9D, 8'h7D:                      d.mode = cpu6502_pkg::MODE_ABX;
      8'hB9, 8'hBE, 8'h99, 8'h79:                      d.mode = cpu6502_pkg::MODE_ABY;
      8'hA5, 8'hA6, 8'hA4, 8'h85, 8'h86, 8'h84, 8'h65: d.mode = cpu6502_pkg::MODE_ZP;
      8'hB5, 8'hB4, 8'h95, 8'h94, 8'h75:               d.mode = cpu6502_pkg::MODE_ZPX;
      8'hB6, 8'h96:                                    d.mode = cpu6502_pkg::MODE_ZPY;
      8'hA1, 8'h81, 8'h61:                             d.mode = cpu6502_pkg::MODE_IZX;
      8'hB1, 8'h91, 8'h71:                             d.mode = cpu6502_pkg::MODE_IZY;
      default:                                         d.mode = cpu6502_pkg::MODE_IMM;
    endcase
    case (op)
      8'hA2, 8'hAE, 8'hBE, 8'hA6, 8'hB6, 8'h8E, 8'h86, 8'h96: d.sel = cpu6502_pkg::REG_X;
      8'hA0, 8'hAC, 8'hBC, 8'hA4, 8'hB4, 8'h8C, 8'h84, 8'h94: d.sel = cpu6502_pkg::REG_Y;
      default:                                                d.sel = cpu6502_pkg::REG_A;
    endcase
    return d;
  endfunction

  // Operand address from the operand bytes; pointers wrap in the zero page
  function automatic logic [15:0] target(input cpu6502_pkg::mode_t m,
                                         input logic [7:0] lo, input logic [7:0] hi);
    logic [7:0] p;
    case (m)
      cpu6502_pkg::MODE_ABS: return {hi, lo};
      cpu6502_pkg::MODE_ABX: return {hi, lo} + {8'h00, x_q};
      cpu6502_pkg::MODE_ABY: return {hi, lo} + {8'h00, y_q};
      cpu6502_pkg::MODE_ZP:  return {8'h00, lo};
      cpu6502_pkg::MODE_ZPX: return {8'h00, lo + x_q};
      cpu6502_pkg::MODE_ZPY: return {8'h00, lo + y_q};
      cpu6502_pkg::MODE_IZX: begin
        p = lo + x_q;
        return {mem_q[{8'h00, p + 8'd1}], mem_q[{8'h00, p}]};
      end
      cpu6502_pkg::MODE_IZY:
        return {mem_q[{8'h00, lo + 8'd1}], mem_q[{8'h00, lo}]} + {8'h00, y_q};
      default:  return 16'h0000;
    endcase
  endfunction

  function automatic void poke(input logic [15:0] a, input logic [7:0] v);
    mem_q[a] = v;
    written_q[a] = 1'b1;
  endfunction

  function automatic logic [7:0] next_byte();
    logic [7:0] b;
    b = mem_q[pc_q];
    pc_q = pc_q + 16'd1;
    return b;
  endfunction

  // Fetch and run one instruction; returns 1 for an unsupported opcode
  function automatic logic run_instruction();
    cpu6502_pkg::decode_t d;
    logic [7:0]  lo, hi, v;
    logic [15:0] ea, ret;
    logic [8:0]  sum;
    d = classify(next_byte());
    case (d.kind)
      cpu6502_pkg::KIND_TXA: begin acc_q = x_q;  flags_q[7:0] = acc_q; end
      cpu6502_pkg::KIND_TYA: begin acc_q = y_q;  flags_q[7:0] = acc_q; end
      cpu6502_pkg::KIND_TAX: begin x_q = acc_q;  flags_q[7:0] = x_q; end
      cpu6502_pkg::KIND_TAY: begin y_q = acc_q;  flags_q[7:0] = y_q; end
      cpu6502_pkg::KIND_TSX: begin x_q = sp_q;   flags_q[7:0] = x_q; end
      cpu6502_pkg::KIND_TXS: sp_q = x_q;
      cpu6502_pkg::KIND_SEC: flags_q[8] = 1'b1;
      cpu6502_pkg::KIND_CLC: flags_q[8] = 1'b0;
      cpu6502_pkg::KIND_NOP: ;
      cpu6502_pkg::KIND_BAD: return 1'b1;
      cpu6502_pkg::KIND_JMP: begin
        lo = next_byte();
        hi = next_byte();
        pc_q = {hi, lo};
      end
      cpu6502_pkg::KIND_JSR: begin
        // push the address of the last byte, high byte first
        ret = pc_q + 16'd1;
        lo = next_byte();
        hi = next_byte();
        poke({8'h01, sp_q}, ret[15:8]);
        poke({8'h01, sp_q - 8'd1}, ret[7:0]);
        sp_q = sp_q - 8'd2;
        pc_q = {hi, lo};
      end
      cpu6502_pkg::KIND_RTS: begin
        ret = {mem_q[{8'h01, sp_q + 8'd2}], mem_q[{8'h01, sp_q + 8'd1}]};
        sp_q = sp_q + 8'd2;
        pc_q = ret + 16'd1;
      end
      default: begin
        if (d.mode == cpu6502_pkg::MODE_IMM) begin
          ea = pc_q;
          pc_q = pc_q + 16'd1;
        end else begin
          lo = next_byte();
          hi = 8'h00;
          if (d.mode inside {cpu6502_pkg::MODE_ABS, cpu6502_pkg::MODE_ABX,
                             cpu6502_pkg::MODE_ABY})
            hi = next_byte();
          ea = target(d.mode, lo, hi);
        end
        if (d.kind == cpu6502_pkg::KIND_LOAD) begin
          v = mem_q[ea];
          case (d.sel)
            cpu6502_pkg::REG_X: x_q = v;
            cpu6502_pkg::REG_Y: y_q = v;
            default:            acc_q = v;
          endcase
          flags_q[7:0] = v;
        end else if (d.kind == cpu6502_pkg::KIND_STORE) begin
          case (d.sel)
            cpu6502_pkg::REG_X: poke(ea, x_q);
            cpu6502_pkg::REG_Y: poke(ea, y_q);
            default:            poke(ea, acc_q);
          endcase
        end else begin
          sum = {1'b0, acc_q} + {8'h00, flags_q[8]} + {1'b0, mem_q[ea]};
          flags_q = sum;
          acc_q = sum[7:0];
        end
      end
    endcase
    return 1'b0;
  endfunction

  function automatic cpu_result_t predict_item(input cpu6502_pkg::cmd_t c,
                                               input logic [15:0] a,
                                               input logic [7:0] wv);
    cpu_result_t r;
    r.rdata  = 8'h00;
    r.bad_op = 1'b0;
    case (c)
      cpu6502_pkg::CMD_WRITE: poke(a, wv);
      cpu6502_pkg::CMD_READ:  r.rdata = mem_q[a];
      cpu6502_pkg::CMD_EXEC: begin
        ran_q = 1'b1;
        r.bad_op = run_instruction();
      end
      default: ;
    endcase
    r.acc = acc_q;
    r.xr  = x_q;
    r.yr  = y_q;
    r.sp  = sp_q;
    r.pc  = pc_q;
    r.c   = flags_q[8];
    r.z   = (flags_q[7:0] == 8'h00);
    r.n   = flags_q[7];
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected 0x%0h, got 0x%0h", $realtime, name, want, got);
    end
  endfunction

  initial begin
    for (int i = 0; i < 65536; i++) begin
      mem_q[i] = 8'h00;
      written_q[i] = 1'b0;
    end
    mismatches = 0;
  end

  // Track configuration, predict on accepted inputs, compare accepted outputs
  always @(posedge clk) begin
    cpu_result_t want, got;
    if (rst) begin
      acc_q = 8'h00; x_q = 8'h00; y_q = 8'h00; sp_q = 8'h00;
      start_q = 16'h0000; pc_q = 16'h0000; flags_q = 9'h001; ran_q = 1'b0;
    end else begin
      if (cfg_we) begin
        start_q = cfg_wdata;
        if (!ran_q) pc_q = cfg_wdata;
      end
      if (in_valid && in_ready)
        results_due.push_back(predict_item(cpu6502_pkg::cmd_t'(command), address,
                                           write_value));
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: result with nothing expected", $realtime);
        end else begin
          want = results_due.pop_front();
          got = '{read_value, accumulator, index_x, index_y, stack_pointer,
                  program_counter, carry_flag, zero_flag, negative_flag, status};
          check_field("read_value", want.rdata, got.rdata);
          check_field("accumulator", want.acc, got.acc);
          check_field("index_x", want.xr, got.xr);
          check_field("index_y", want.yr, got.yr);
          check_field("stack_pointer", want.sp, got.sp);
          check_field("program_counter", want.pc, got.pc);
          check_field("carry_flag", want.c, got.c);
          check_field("zero_flag", want.z, got.z);
          check_field("negative_flag", want.n, got.n);
          check_field("status", want.bad_op, got.bad_op);
        end
      end
    end
  end

endmodule

// ----- verif/tb_cpu6502_subset_executor.sv -----
// ----------------------------------------------------------------------------
// 6502 subset executor testbench
// Lays down small programs byte by byte and executes them one instruction at
// a time, mixed with memory reads, writes and idle commands, under random
// gaps and stalls on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_cpu6502_subset_executor;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TOTAL = 1350;
  localparam int HOLD_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'h0000;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = cpu6502_pkg::CMD_NONE;
  logic [15:0] address = 16'h0000;
  logic [7:0]  write_value = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  read_value, accumulator, index_x, index_y, stack_pointer;
  logic [15:0] program_counter;
  logic        carry_flag, zero_flag, negative_flag, status;
  int          fail_count;

  int          items_sent = 0;
  int          exec_count = 0;
  int          read_count = 0;
  int          cfg_count = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  logic [15:0] touched [$];

  always #5 clk = ~clk;

  cpu6502_subset_executor dut (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .in_valid, .in_ready, .command, .address, .write_value,
    .out_valid, .out_ready, .read_value, .accumulator, .index_x, .index_y,
    .stack_pointer, .program_counter, .carry_flag, .zero_flag, .negative_flag,
    .status
  );

  cpu6502_subset_checker chk (.*);

  // Hard stop for a hung run
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready <= quiet || ($urandom_range(0, 99) >= 25);
      @(negedge clk);
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'h80;
      2:       return 8'hFF;
      3:       return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one item and hold it until accepted
  task automatic send_item(input cpu6502_pkg::cmd_t c, input logic [15:0] a,
                           input logic [7:0] v);
    if (!quiet && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    address <= a;
    write_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (c == cpu6502_pkg::CMD_WRITE) begin
      touched.push_back(a);
      if (touched.size() > 64) void'(touched.pop_front());
    end
  endtask

  // Give a byte a value only if it has never been written
  task automatic fill_if_blank(input logic [15:0] a);
    if (!chk.written_q[a]) send_item(cpu6502_pkg::CMD_WRITE, a, pick_byte());
  endtask

  // Store the instruction at PC, fill whatever it reads, then execute it
  task automatic run_op(input logic [7:0] op, input logic [7:0] lo, input logic [7:0] hi);
    cpu6502_pkg::decode_t d;
    int          nbytes;
    logic [15:0] pc;
    logic [7:0]  p;
    d = chk.classify(op);
    pc = chk.pc_q;
    nbytes = 0;
    if (d.kind inside {cpu6502_pkg::KIND_LOAD, cpu6502_pkg::KIND_STORE,
                       cpu6502_pkg::KIND_ADC})
      nbytes = (d.mode inside {cpu6502_pkg::MODE_ABS, cpu6502_pkg::MODE_ABX,
                               cpu6502_pkg::MODE_ABY}) ? 2 : 1;
    else if (d.kind inside {cpu6502_pkg::KIND_JMP, cpu6502_pkg::KIND_JSR})
      nbytes = 2;
    send_item(cpu6502_pkg::CMD_WRITE, pc, op);
    if (nbytes >= 1) send_item(cpu6502_pkg::CMD_WRITE, pc + 16'd1, lo);
    if (nbytes == 2) send_item(cpu6502_pkg::CMD_WRITE, pc + 16'd2, hi);
    if (d.kind inside {cpu6502_pkg::KIND_LOAD, cpu6502_pkg::KIND_STORE,
                       cpu6502_pkg::KIND_ADC}) begin
      p = (d.mode == cpu6502_pkg::MODE_IZX) ? lo + chk.x_q : lo;
      if (d.mode inside {cpu6502_pkg::MODE_IZX, cpu6502_pkg::MODE_IZY}) begin
        fill_if_blank({8'h00, p});
        fill_if_blank({8'h00, p + 8'd1});
      end
      if (d.kind != cpu6502_pkg::KIND_STORE && d.mode != cpu6502_pkg::MODE_IMM)
        fill_if_blank(chk.target(d.mode, lo, hi));
    end
    if (d.kind == cpu6502_pkg::KIND_RTS) begin
      fill_if_blank({8'h01, chk.sp_q + 8'd1});
      fill_if_blank({8'h01, chk.sp_q + 8'd2});
    end
    send_item(cpu6502_pkg::CMD_EXEC, 16'($urandom), 8'($urandom));
    exec_count++;
  endtask

  // Stop offering and wait for every result plus the block's latency
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (chk.results_due.size() != 0) @(negedge clk);
    repeat (15) @(negedge clk);
  endtask

  task automatic write_start(input logic [15:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    cfg_count++;
  endtask

  // One random step, mostly well-formed instructions
  task automatic random_step();
    logic [7:0] op, lo, hi;
    int         sel;
    logic [7:0] known_ops [52] = '{
      8'hA9, 8'hA2, 8'hA0, 8'hAD, 8'hAE, 8'hAC, 8'hBD, 8'hBC, 8'hB9, 8'hBE,
      8'hA5, 8'hA6, 8'hA4, 8'hB5, 8'hB4, 8'hB6, 8'hA1, 8'hB1, 8'h8D, 8'h8E,
      8'h8C, 8'h9D, 8'h99, 8'h85, 8'h86, 8'h84, 8'h95, 8'h94, 8'h96, 8'h81,
      8'h91, 8'h69, 8'h6D, 8'h7D, 8'h79, 8'h65, 8'h75, 8'h61, 8'h71, 8'h8A,
      8'h98, 8'hA8, 8'hAA, 8'hBA, 8'h9A, 8'h4C, 8'h20, 8'h60, 8'h38, 8'h18,
      8'hEA, 8'hFF};
    sel = $urandom_range(0, 99);
    lo = pick_byte();
    case ($urandom_range(0, 2))
      0:       hi = 8'h00;
      1:       hi = 8'h01;
      default: hi = 8'($urandom);
    endcase
    if (sel < 75) begin
      op = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                        : known_ops[$urandom_range(0, 51)];
      run_op(op, lo, hi);
    end else if (sel < 87 && touched.size() != 0) begin
      send_item(cpu6502_pkg::CMD_READ, touched[$urandom_range(0, touched.size() - 1)],
                8'($urandom));
      read_count++;
    end else if (sel < 96) begin
      send_item(cpu6502_pkg::CMD_WRITE, 16'($urandom), pick_byte());
    end else begin
      send_item(cpu6502_pkg::CMD_NONE, 16'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    bit          held;
    logic [15:0] starts [3];
    held = 1'b0;
    starts = '{16'($urandom), 16'hFFFF, 16'h0000};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Both start writes before any instruction reload PC
    write_start(16'h0000);
    write_start(16'hFFFF);

    // Directed: PC wrap, flags, carry chain, stack, jumps, bad opcodes
    run_op(8'hEA, 8'h00, 8'h00);
    run_op(8'hA9, 8'h00, 8'h00);
    run_op(8'hA9, 8'h80, 8'h00);
    run_op(8'h69, 8'hFF, 8'h00);
    run_op(8'h69, 8'h00, 8'h00);
    run_op(8'h38, 8'h00, 8'h00);
    run_op(8'h18, 8'h00, 8'h00);
    run_op(8'hA2, 8'hFF, 8'h00);
    run_op(8'h9A, 8'h00, 8'h00);
    run_op(8'hBA, 8'h00, 8'h00);
    run_op(8'h20, 8'h00, 8'h02);
    run_op(8'h60, 8'h00, 8'h00);
    run_op(8'hA0, 8'hFF, 8'h00);
    run_op(8'hB1, 8'hFF, 8'h00);
    run_op(8'hA1, 8'h00, 8'h00);
    run_op(8'hB6, 8'h80, 8'h00);
    run_op(8'h4C, 8'h34, 8'h12);
    run_op(8'hFF, 8'h00, 8'h00);
    run_op(8'hCF, 8'h00, 8'h00);
    send_item(cpu6502_pkg::CMD_NONE, 16'hFFFF, 8'hFF);
    send_item(cpu6502_pkg::CMD_READ, 16'h01FF, 8'h00);
    read_count++;
    drain();

    // Random phases, start address rewritten between them
    for (int ph = 0; ph < 3; ph++) begin
      while (items_sent < (ph + 1) * ITEM_TOTAL / 3) begin
        quiet = (items_sent >= 500 && items_sent < 700);
        if (!held && items_sent >= 900) begin
          hold_req = 1'b1;
          held = 1'b1;
        end
        random_step();
      end
      quiet = 1'b0;
      drain();
      write_start(starts[ph]);
    end

    drain();
    $display("Sent %0d items: %0d instructions, %0d reads, %0d start address writes.",
             items_sent, exec_count, read_count, cfg_count);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/cpu6502_pkg.sv
hw/rtl/cpu6502_mem.sv
hw/rtl/cpu6502_subset_executor.sv
verif/cpu6502_subset_checker.sv
verif/tb_cpu6502_subset_executor.sv
